// ===== hw/rtl/bss_pkg.sv =====
// Shared types and constants for the block sample statistics core.
// Used by bss_iter and block_sample_statistics_core.
package bss_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS     = 16;
  localparam int ROOT_W          = 16;
  localparam int RAD_W           = 2 * ROOT_W;
  localparam int REM_W           = 20;
  localparam int OUT_W           = 128;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } bss_op_t;

  typedef struct packed {
    logic    start;
    bss_op_t op;
  } bss_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bss_rsp_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_MEAN,
    ST_RMS_DIV,
    ST_RMS_SQRT,
    ST_PASS,
    ST_DRAIN,
    ST_MAD,
    ST_VAR,
    ST_SD,
    ST_DONE
  } bss_state_t;

endpackage

// ===== hw/rtl/bss_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
module bss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/bss_iter.sv =====
// Shared iterative unit: restoring unsigned divide (one quotient bit per
// cycle) and floor square root (one root bit per cycle). Uses bss_pkg.
module bss_iter #(
  parameter int DW = 45,
  parameter int CW = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bss_pkg::bss_req_t req,
  input  logic [DW-1:0]     a,
  input  logic [CW-1:0]     b,
  output bss_pkg::bss_rsp_t rsp,
  output logic [DW-1:0]     result
);
  import bss_pkg::*;

  localparam int SW = $clog2(DW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SW-1:0]     cnt_r, cnt_nxt;
  bss_op_t           op_r, op_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]     acc_r, acc_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CW-1:0]     div_r, div_nxt;
  logic [REM_W-1:0]  sh, trial;
  logic              ge;

  always_comb begin
    if (op_r == OP_DIV) begin
      sh    = {rem_r[REM_W-2:0], acc_r[DW-1]};
      trial = REM_W'(div_r);
    end else begin
      sh    = {rem_r[REM_W-3:0], acc_r[RAD_W-1:RAD_W-2]};
      trial = REM_W'({root_r, 2'b01});
    end
    ge = (sh >= trial);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    root_nxt = root_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      rem_nxt  = '0;
      acc_nxt  = a;
      root_nxt = '0;
      div_nxt  = b;
      cnt_nxt  = (req.op == OP_DIV) ? SW'(DW) : SW'(ROOT_W);
    end else if (busy_r) begin
      rem_nxt = ge ? (sh - trial) : sh;
      if (op_r == OP_DIV) begin
        acc_nxt = {acc_r[DW-2:0], ge};
      end else begin
        acc_nxt  = acc_r << 2;
        root_nxt = {root_r[ROOT_W-2:0], ge};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    root_r <= root_nxt;
    div_r  <= div_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = (op_r == OP_DIV) ? acc_r : DW'(root_r);
endmodule

// ===== hw/rtl/block_sample_statistics_core.sv =====
// Block sample statistics: top level.
// Uses bss_pkg, bss_ram (sample store) and bss_iter (divide / sqrt unit).
//
// Input channel in_*: one signed sample per item in in_tdata, in_tlast marks
// the last sample of a block. Samples are taken one per cycle while the
// block collects; max, min, sum and sum of squares update on the fly and
// each sample is written to the store. Samples beyond MAX_SAMPLES are
// dropped and flag overflowed.
// After the last item in_tready drops while the closing sequence runs:
// mean divide, RMS divide and root, a second pass over the n stored
// samples, then MAD and variance divides and the std-dev root. The divides
// and roots run through the one shared iterative unit, one bit per cycle;
// its divide width is DW = 34 + counter width, 45 at the default depth.
// Output channel out_*: one item per block in a holding register; the next
// block is collected while it waits. If the receiver stalls with a result
// still held, the next closing sequence waits in its final step.
// Reset (rst_n low, synchronous) empties the block and the output register.
// The store itself is not cleared; only entries of the current block are read.
module block_sample_statistics_core #(
  parameter int MAX_SAMPLES = bss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bss_pkg::SAMPLE_BITS-1:0] in_tdata,  // sample
  input  logic                          in_tlast,    // last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // max_value, min_value, mean_value, rms_value, mean_abs_dev,
  // variance_value, std_dev
  output logic [bss_pkg::OUT_W-1:0]     out_tdata,
  output logic                          out_tuser    // overflowed
);
  import bss_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;
  localparam int D_W   = SAMPLE_BITS + 1;
  localparam int ABS_W = D_W + CNT_W;
  localparam int DW    = 2 * D_W + CNT_W;

  bss_state_t state_r, state_nxt;

  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt, min_r, min_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SQ_W-1:0]               sumsq_r, sumsq_nxt;
  logic                          drop_r, drop_nxt;
  logic                          launched_r, launched_nxt;
  logic signed [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic [RAD_W-1:0]              quot_r, quot_nxt;
  logic [ROOT_W-1:0]             rms_r, rms_nxt, sd_r, sd_nxt;
  logic [ROOT_W-1:0]             mad_r, mad_nxt;
  logic [RAD_W-1:0]              var_r, var_nxt;
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic                          v1_r, v1_nxt, v2_r, v2_nxt;
  logic [D_W-1:0]                d_r, d_nxt;
  logic [ABS_W-1:0]              abs_acc_r, abs_acc_nxt;
  logic [DW-1:0]                 sq_acc_r, sq_acc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]              out_data_r, out_data_nxt;
  logic                          out_user_r, out_user_nxt;

  logic                          in_acc, arith_st, load_out;
  logic signed [SAMPLE_BITS-1:0] x, rd_x;
  logic signed [2*SAMPLE_BITS-1:0] x_sq;
  logic signed [D_W-1:0]         dif;
  logic [2*D_W-1:0]              d_sq;
  logic [SUM_W-1:0]              sum_mag;
  logic [DW-1:0]                 u_a, u_res;
  bss_req_t                      req;
  bss_rsp_t                      rsp;
  logic                          store_we;

  bss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(cnt_r[AW-1:0]),
    .wdata(in_tdata),
    .raddr(idx_r[AW-1:0]),
    .rdata(rd_x)
  );

  bss_iter #(.DW(DW), .CW(CNT_W)) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .a     (u_a),
    .b     (cnt_r),
    .rsp   (rsp),
    .result(u_res)
  );

  assign x        = in_tdata;
  assign x_sq     = x * x;
  assign in_acc   = in_tvalid && in_tready;
  assign store_we = in_acc && (cnt_r < CNT_W'(MAX_SAMPLES));
  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign dif      = D_W'(mean_r) - D_W'(rd_x);
  assign d_sq     = d_r * d_r;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT:  if (in_acc && in_tlast) state_nxt = ST_MEAN;
      ST_MEAN:     if (rsp.done) state_nxt = ST_RMS_DIV;
      ST_RMS_DIV:  if (rsp.done) state_nxt = ST_RMS_SQRT;
      ST_RMS_SQRT: if (rsp.done) state_nxt = ST_PASS;
      ST_PASS:     if (idx_r == cnt_r - 1'b1) state_nxt = ST_DRAIN;
      ST_DRAIN:    if (!v1_r && !v2_r) state_nxt = ST_MAD;
      ST_MAD:      if (rsp.done) state_nxt = ST_VAR;
      ST_VAR:      if (rsp.done) state_nxt = ST_SD;
      ST_SD:       if (rsp.done) state_nxt = ST_DONE;
      ST_DONE:     if (load_out) state_nxt = ST_COLLECT;
      default:     state_nxt = ST_COLLECT;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == ST_COLLECT);
    arith_st  = 1'b0;
    req.op    = OP_DIV;
    u_a       = '0;
    unique case (state_r)
      ST_MEAN: begin
        arith_st = 1'b1;
        u_a      = DW'(sum_mag);
      end
      ST_RMS_DIV: begin
        arith_st = 1'b1;
        u_a      = DW'(sumsq_r);
      end
      ST_RMS_SQRT: begin
        arith_st = 1'b1;
        req.op   = OP_SQRT;
        u_a      = DW'(quot_r);
      end
      ST_MAD: begin
        arith_st = 1'b1;
        u_a      = DW'(abs_acc_r);
      end
      ST_VAR: begin
        arith_st = 1'b1;
        u_a      = sq_acc_r;
      end
      ST_SD: begin
        arith_st = 1'b1;
        req.op   = OP_SQRT;
        u_a      = DW'(var_r);
      end
      default: arith_st = 1'b0;
    endcase
    req.start = arith_st && !launched_r;
  end

  // datapath
  always_comb begin
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    drop_nxt      = drop_r;
    mean_nxt      = mean_r;
    quot_nxt      = quot_r;
    rms_nxt       = rms_r;
    mad_nxt       = mad_r;
    var_nxt       = var_r;
    sd_nxt        = sd_r;
    idx_nxt       = idx_r;
    v1_nxt        = 1'b0;
    v2_nxt        = v1_r;
    d_nxt         = dif[D_W-1] ? D_W'(-dif) : D_W'(dif);
    abs_acc_nxt   = abs_acc_r;
    sq_acc_nxt    = sq_acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    launched_nxt  = launched_r;

    if (req.start) launched_nxt = 1'b1;
    if (rsp.done) launched_nxt = 1'b0;

    if (store_we) begin
      cnt_nxt   = cnt_r + 1'b1;
      if (x > max_r) max_nxt = x;
      if (x < min_r) min_nxt = x;
      sum_nxt   = sum_r + SUM_W'(x);
      sumsq_nxt = sumsq_r + SQ_W'($unsigned(x_sq));
    end else if (in_acc) begin
      drop_nxt = 1'b1;
    end

    if (state_r == ST_COLLECT) begin
      idx_nxt     = '0;
      abs_acc_nxt = '0;
      sq_acc_nxt  = '0;
    end

    if (rsp.done) begin
      case (state_r)
        ST_MEAN:     mean_nxt = sum_r[SUM_W-1] ? -SAMPLE_BITS'(u_res)
                                               : SAMPLE_BITS'(u_res);
        ST_RMS_DIV:  quot_nxt = RAD_W'(u_res);
        ST_RMS_SQRT: rms_nxt  = ROOT_W'(u_res);
        ST_MAD:      mad_nxt  = ROOT_W'(u_res);
        ST_VAR:      var_nxt  = RAD_W'(u_res);
        ST_SD:       sd_nxt   = ROOT_W'(u_res);
        default:     ;
      endcase
    end

    if (state_r == ST_PASS) begin
      v1_nxt  = 1'b1;
      idx_nxt = idx_r + 1'b1;
    end
    if (v2_r) begin
      abs_acc_nxt = abs_acc_r + ABS_W'(d_r);
      sq_acc_nxt  = sq_acc_r + DW'(d_sq);
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {sd_r, var_r, mad_r, rms_r, mean_r, min_r, max_r};
      out_user_nxt  = drop_r;
      cnt_nxt       = '0;
      max_nxt       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      min_nxt       = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      sum_nxt       = '0;
      sumsq_nxt     = '0;
      drop_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      cnt_r       <= '0;
      max_r       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      min_r       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      sum_r       <= '0;
      sumsq_r     <= '0;
      drop_r      <= 1'b0;
      launched_r  <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      drop_r      <= drop_nxt;
      launched_r  <= launched_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mean_r     <= mean_nxt;
    quot_r     <= quot_nxt;
    rms_r      <= rms_nxt;
    mad_r      <= mad_nxt;
    var_r      <= var_nxt;
    sd_r       <= sd_nxt;
    idx_r      <= idx_nxt;
    d_r        <= d_nxt;
    abs_acc_r  <= abs_acc_nxt;
    sq_acc_r   <= sq_acc_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count past store depth");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !rsp.busy)
    else $error("unit started while busy");

  a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> launched_r)
    else $error("unit done without a request");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> !in_tready)
    else $error("input still ready after last item");

endmodule
